@@ src/dlmr_pkg.sv @@
// ----------------------------------------------------------------------------
// dlmr_pkg
// Shared types and constants for the diagonal longest-match realign block.
// ----------------------------------------------------------------------------
package dlmr_pkg;

  localparam int unsigned BufferDepth   = 4096;
  localparam int unsigned AddrW         = $clog2(BufferDepth);
  localparam int unsigned LenW          = AddrW + 1;
  localparam int unsigned RealignWindow = 32;
  localparam int unsigned OffW          = $clog2(RealignWindow + 1);
  localparam int unsigned ProbeBytes    = 8;
  localparam int unsigned ProbeW        = $clog2(ProbeBytes + 1);

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_RUN    = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  // controller to datapath
  typedef struct packed {
    logic load_a;     // write data byte at length_a
    logic load_b;
    logic walk_init;  // clear walk registers
    logic rd_main;    // read A[i], B[j]
    logic step_main;  // act on compared bytes
    logic rd_probe;   // read A[i+k], B[j+off+k]
    logic step_probe; // act on probe compare
    logic finish;     // fold last run, clear lengths
  } dlmr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic walk_done;   // i or j at end
    logic go_probe;    // main step decided to realign
    logic stop_early;  // early stop fired
    logic probe_done;  // probe search finished (result applied)
  } dlmr_stat_t;

endpackage

@@ src/dlmr_datapath.sv @@
// ----------------------------------------------------------------------------
// dlmr_datapath
// Byte buffers A and B: loads, fill counts, overflow flag and registered reads.
// ----------------------------------------------------------------------------
module dlmr_datapath import dlmr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load_a,
  input  logic             load_b,
  input  logic             clear,
  input  logic             rd_en,
  input  logic [7:0]       data_byte,
  input  logic [AddrW-1:0] addr_a,
  input  logic [AddrW-1:0] addr_b,
  output logic [7:0]       rd_a,
  output logic [7:0]       rd_b,
  output logic [LenW-1:0]  length_a,
  output logic [LenW-1:0]  length_b,
  output logic             overflow_seen
);

  logic [7:0] mem_a [BufferDepth];
  logic [7:0] mem_b [BufferDepth];
  logic       room_a, room_b;

  assign room_a = (length_a < LenW'(BufferDepth));
  assign room_b = (length_b < LenW'(BufferDepth));

  always_ff @(posedge clk) begin
    if (load_a && room_a) mem_a[length_a[AddrW-1:0]] <= data_byte;
    if (load_b && room_b) mem_b[length_b[AddrW-1:0]] <= data_byte;
    if (rd_en) begin
      rd_a <= mem_a[addr_a];
      rd_b <= mem_b[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_a      <= '0;
      length_b      <= '0;
      overflow_seen <= 1'b0;
    end else begin
      // drop the byte and flag it once the buffer is full
      if (load_a) begin
        if (room_a) length_a <= length_a + 1'b1;
        else overflow_seen <= 1'b1;
      end
      if (load_b) begin
        if (room_b) length_b <= length_b + 1'b1;
        else overflow_seen <= 1'b1;
      end
      if (clear) begin
        length_a <= '0; length_b <= '0; overflow_seen <= 1'b0;
      end
    end
  end

endmodule

@@ src/dlmr_ctrl.sv @@
// ----------------------------------------------------------------------------
// dlmr_ctrl
// Sequencer for loads, the diagonal walk and the realign probe.
// ----------------------------------------------------------------------------
module dlmr_ctrl import dlmr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  dlmr_stat_t stat,
  output dlmr_cmd_t  cmd,
  output logic       out_valid,
  input  logic       out_ready
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_STEP  = 7'b0000100,
    S_PRD   = 7'b0001000,
    S_PSTEP = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   acc;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign acc       = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (opcode_t'(opcode))
            OP_LOAD_A: cmd.load_a = 1'b1;
            OP_LOAD_B: cmd.load_b = 1'b1;
            OP_RUN: begin
              cmd.walk_init = 1'b1;
              state_next    = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        cmd.rd_main = 1'b1;
        state_next  = stat.walk_done ? S_FIN : S_STEP;
      end
      S_STEP: begin
        cmd.step_main = 1'b1;
        if (stat.go_probe) state_next = S_PRD;
        else if (stat.stop_early) state_next = S_FIN;
        else state_next = S_RD;
      end
      S_PRD: begin
        cmd.rd_probe = 1'b1;
        state_next   = S_PSTEP;
      end
      S_PSTEP: begin
        cmd.step_probe = 1'b1;
        state_next     = stat.probe_done ? S_RD : S_PRD;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

@@ src/diagonal_longest_match_realign.sv @@
// ----------------------------------------------------------------------------
// diagonal_longest_match_realign
// Loads two byte buffers and reports their longest diagonal run with realign.
// ----------------------------------------------------------------------------
// Loads are taken back to back while idle; opcode 3 is accepted and dropped.
// A run starts, then reads and steps for each walk step and for each probe
// compare (plus one read and step to find the window used up), makes a final
// end test unless it stops early and folds, then holds the result until taken;
// the single registered read port per buffer sets this.
// Synchronous reset clears lengths, overflow flag and the sequencer.
module diagonal_longest_match_realign import dlmr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] match_start_a,
  output logic [11:0] match_start_b,
  output logic [12:0] match_length,
  output logic        load_overflow
);

  dlmr_cmd_t  cmd;
  dlmr_stat_t stat;
  logic [AddrW-1:0] ba, bb;
  logic [LenW-1:0]  bl;

  dlmr_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .opcode, .stat, .cmd,
    .out_valid, .out_ready
  );

  dlmr_dp u_dp (
    .clk, .rst, .cmd, .data_byte, .stat,
    .best_a_out(ba), .best_b_out(bb), .best_out(bl), .overflow_out(load_overflow)
  );

  assign match_start_a = 12'(ba);
  assign match_start_b = 12'(bb);
  assign match_length  = 13'(bl);

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(match_length))
    else $error("result changed while held");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken during result");
  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> match_length != '0 || (match_start_a == '0 && match_start_b == '0))
    else $error("start without run");

endmodule

@@ src/dlmr_dp.sv @@
// ----------------------------------------------------------------------------
// dlmr_dp
// Datapath: buffers, walk indices, best-run tracking and realign probe.
// ----------------------------------------------------------------------------
module dlmr_dp import dlmr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  dlmr_cmd_t         cmd,
  input  logic [7:0]        data_byte,
  output dlmr_stat_t        stat,
  output logic [AddrW-1:0]  best_a_out,
  output logic [AddrW-1:0]  best_b_out,
  output logic [LenW-1:0]   best_out,
  output logic              overflow_out
);

  logic [7:0]        rd_a, rd_b;
  logic [AddrW-1:0]  addr_a, addr_b;
  logic [LenW-1:0]   length_a, length_b, na, nb;
  logic              overflow_seen, overflow_res;
  logic [LenW-1:0]   i, j, count, best, best_a, best_b;
  logic [OffW-1:0]   off;
  logic [ProbeW-1:0] k;
  logic [LenW-1:0]   a_left, b_left, span, probe;
  logic [LenW:0]     pa_addr, pb_addr, off_ext;
  logic              same, off_ok, probe_hit, probe_miss, probe_fin, room;

  assign a_left  = na - i;
  assign b_left  = nb - j;
  assign span    = (a_left < b_left) ? a_left : b_left;
  assign probe   = (span < LenW'(ProbeBytes)) ? span : LenW'(ProbeBytes);
  assign off_ext = (LenW+1)'(off);
  assign pa_addr = {1'b0, i} + (LenW+1)'(k);
  assign pb_addr = {1'b0, j} + off_ext + (LenW+1)'(k);
  assign addr_a  = cmd.rd_probe ? pa_addr[AddrW-1:0] : i[AddrW-1:0];
  assign addr_b  = cmd.rd_probe ? pb_addr[AddrW-1:0] : j[AddrW-1:0];

  dlmr_datapath u_buf (
    .clk, .rst,
    .load_a(cmd.load_a), .load_b(cmd.load_b), .clear(cmd.finish),
    .rd_en(cmd.rd_main || cmd.rd_probe),
    .data_byte, .addr_a, .addr_b, .rd_a, .rd_b,
    .length_a, .length_b, .overflow_seen
  );

  assign same   = (rd_a == rd_b);
  // candidate offset lies in the window and leaves room for the span in B
  assign off_ok = (off_ext < (LenW+1)'(RealignWindow)) && (off_ext <= {1'b0, b_left})
                  && ({1'b0, span} <= {1'b0, b_left} - off_ext);
  // an empty probe matches at once, whatever bytes were read
  assign probe_hit  = cmd.step_probe && off_ok &&
                      (probe == '0 || (same && (LenW'(k) + 1'b1) >= probe));
  assign probe_miss = cmd.step_probe && !off_ok;
  assign probe_fin  = probe_hit || probe_miss;

  // early stop: the rest of A or B from the mismatch is no longer than the run
  assign room = (count >= a_left) || (count >= b_left);

  assign stat.walk_done  = !(i < na && j < nb);
  assign stat.go_probe   = cmd.step_main && !same && (count == '0);
  assign stat.stop_early = cmd.step_main && !same && (count != '0) && (count > best) && room;
  assign stat.probe_done = probe_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      i <= '0; j <= '0; count <= '0; best <= '0; best_a <= '0; best_b <= '0;
      off <= '0; k <= '0; na <= '0; nb <= '0; overflow_res <= 1'b0;
    end else begin
      if (cmd.walk_init) begin
        i <= '0; j <= '0; count <= '0; best <= '0; best_a <= '0; best_b <= '0;
        na <= length_a; nb <= length_b; off <= '0; k <= '0;
      end
      if (cmd.step_main) begin
        if (same) begin
          count <= count + 1'b1; i <= i + 1'b1; j <= j + 1'b1;
        end else if (count == '0) begin
          off <= '0; k <= '0;
        end else begin
          if (count > best) begin
            best_a <= i - count; best_b <= j - count; best <= count;
          end
          count <= '0;
          // hold indices on early stop so nothing else is folded
          if (!stat.stop_early) begin
            i <= i + 1'b1; j <= j + 1'b1;
          end
        end
      end
      if (cmd.step_probe) begin
        if (probe_hit) begin
          k <= '0;
          if (off != '0) j <= j + LenW'(off);
          else begin i <= i + 1'b1; j <= j + 1'b1; end
        end else if (probe_miss) begin
          k <= '0; i <= i + 1'b1; j <= j + 1'b1;
        end else if (same) begin
          k <= k + 1'b1;
        end else begin
          k <= '0; off <= off + 1'b1;
        end
      end
      if (cmd.finish) begin
        if (count > best) begin
          best_a <= i - count; best_b <= j - count; best <= count;
        end
        // keep the flag for the result; the buffer store clears its own
        overflow_res <= overflow_seen;
      end
    end
  end

  assign best_out     = best;
  assign best_a_out   = (best == '0) ? '0 : best_a[AddrW-1:0];
  assign best_b_out   = (best == '0) ? '0 : best_b[AddrW-1:0];
  assign overflow_out = overflow_res;

endmodule

@@ tb/diagonal_longest_match_realign_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diagonal_longest_match_realign_tb
// Loads byte pairs into both buffers and runs the longest-match search. Each
// search result is checked field by field against a software match search.
// Both handshakes see random idle bursts, and one full buffer forces overflow.
// ----------------------------------------------------------------------------
module diagonal_longest_match_realign_tb import dlmr_pkg::*; ();

  typedef struct {
    opcode_t    op;
    logic [7:0] data;
    bit         drain_first;  // hold until every expected result is in
  } load_item_t;

  typedef struct {
    logic [11:0] start_a;
    logic [11:0] start_b;
    logic [12:0] length;
    logic        overflow;
  } match_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = OP_NONE;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [11:0] match_start_a;
  logic [11:0] match_start_b;
  logic [12:0] match_length;
  logic        load_overflow;

  diagonal_longest_match_realign u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .match_start_a(match_start_a), .match_start_b(match_start_b),
    .match_length(match_length), .load_overflow(load_overflow)
  );

  always #5 clk = ~clk;

  load_item_t  pending_items[$];
  match_t      expected_matches[$];
  logic [7:0]  mem_a[BufferDepth];
  logic [7:0]  mem_b[BufferDepth];
  int unsigned held_a = 0;
  int unsigned held_b = 0;
  bit          dropped = 1'b0;
  int unsigned issued = 0;
  int unsigned accepted = 0;
  int unsigned matches_seen = 0;
  int unsigned errors = 0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  bit          quiet = 1'b0;
  bit          stim_done = 1'b0;

  // Offset ahead in B where the next bytes of A line up again, or 0.
  function automatic int unsigned realign_gap(int unsigned pa, int unsigned a_left,
                                              int unsigned pb, int unsigned b_left);
    int unsigned span;
    int unsigned probe;
    bit same;
    span  = a_left < b_left ? a_left : b_left;
    probe = span < ProbeBytes ? span : ProbeBytes;
    for (int unsigned off = 0; off < RealignWindow && off <= b_left && span <= b_left - off;
         off++) begin
      same = 1'b1;
      for (int unsigned k = 0; k < probe; k++)
        if (mem_a[pa + k] != mem_b[pb + off + k]) begin
          same = 1'b0;
          break;
        end
      if (same) return off;
    end
    return 0;
  endfunction

  function automatic match_t longest_run();
    int unsigned i, j, count, best, best_a, best_b, off;
    match_t m;
    i = 0; j = 0; count = 0; best = 0; best_a = 0; best_b = 0;
    while (i < held_a && j < held_b) begin
      if (mem_a[i] == mem_b[j]) begin
        count++; i++; j++;
        continue;
      end
      if (count == 0) begin
        off = realign_gap(i, held_a - i, j, held_b - j);
        if (off > 0) j += off;
        else begin i++; j++; end
        continue;
      end
      if (count > best) begin
        best_a = i - count;
        best_b = j - count;
        best   = count;
        if (best >= held_a - i || best >= held_b - j) break;
      end
      count = 0; i++; j++;
    end
    if (count > best) begin
      best_a = i - count;
      best_b = j - count;
      best   = count;
    end
    if (best == 0) begin
      best_a = 0;
      best_b = 0;
    end
    m.start_a  = best_a[11:0];
    m.start_b  = best_b[11:0];
    m.length   = best[12:0];
    m.overflow = dropped;
    return m;
  endfunction

  function automatic void apply_item(logic [1:0] op, logic [7:0] d);
    case (op)
      OP_LOAD_A: begin
        if (held_a < BufferDepth) begin mem_a[held_a] = d; held_a++; end
        else dropped = 1'b1;
      end
      OP_LOAD_B: begin
        if (held_b < BufferDepth) begin mem_b[held_b] = d; held_b++; end
        else dropped = 1'b1;
      end
      OP_RUN: begin
        expected_matches.push_back(longest_run());
        held_a = 0;
        held_b = 0;
        dropped = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // Monitor: predict on accepted inputs, check accepted results.
  always @(posedge clk) begin
    match_t m;
    if (!rst) begin
      if (in_valid && in_ready) begin
        accepted <= accepted + 1;
        apply_item(opcode, data_byte);
      end
      if (out_valid && out_ready) begin
        matches_seen <= matches_seen + 1;
        if (expected_matches.size() == 0) begin
          $error("unexpected result: start_a %0d start_b %0d length %0d",
                 match_start_a, match_start_b, match_length);
          errors++;
        end else begin
          m = expected_matches.pop_front();
          if (match_start_a !== m.start_a) begin
            $error("match_start_a expected %0d actual %0d", m.start_a, match_start_a);
            errors++;
          end
          if (match_start_b !== m.start_b) begin
            $error("match_start_b expected %0d actual %0d", m.start_b, match_start_b);
            errors++;
          end
          if (match_length !== m.length) begin
            $error("match_length expected %0d actual %0d", m.length, match_length);
            errors++;
          end
          if (load_overflow !== m.overflow) begin
            $error("load_overflow expected %0d actual %0d", m.overflow, load_overflow);
            errors++;
          end
        end
      end
    end
  end

  // Driver: present the next item, with idle bursts between items.
  always @(negedge clk) begin
    load_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && issued != accepted) begin
      // hold until taken
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_items.size() != 0 &&
                 !(pending_items[0].drain_first && expected_matches.size() != 0)) begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        in_gap <= $urandom_range(1, 17) - 1;
        in_valid <= 1'b0;
      end else begin
        it = pending_items.pop_front();
        opcode    <= it.op;
        data_byte <= it.data;
        in_valid  <= 1'b1;
        issued    <= issued + 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stalls in bursts.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      out_stall <= $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic push_item(opcode_t op, logic [7:0] d, bit drain = 1'b0);
    load_item_t it;
    it.op = op;
    it.data = d;
    it.drain_first = drain;
    pending_items.push_back(it);
  endtask

  // Random content: small alphabet most of the time so runs appear.
  function automatic logic [7:0] pick_byte(bit narrow);
    return narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int unsigned items;
    int unsigned runs;
    int unsigned na, nb, lead;
    bit narrow;
    logic [7:0] seq_a[$];
    logic [7:0] seq_b[$];

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty search, extremes, unused opcode, realign, early stop.
    push_item(OP_RUN, 8'h00);
    push_item(OP_LOAD_A, 8'h00);
    push_item(OP_LOAD_A, 8'hFF);
    push_item(OP_LOAD_B, 8'h00);
    push_item(OP_LOAD_B, 8'hFF);
    push_item(OP_NONE, 8'hA5);
    push_item(OP_RUN, 8'hFF);
    push_item(OP_LOAD_A, 8'h12);
    push_item(OP_LOAD_B, 8'h34);
    push_item(OP_RUN, 8'h5A, 1'b1);
    push_item(OP_LOAD_A, 8'h01);
    push_item(OP_LOAD_A, 8'h02);
    push_item(OP_LOAD_A, 8'h03);
    push_item(OP_LOAD_B, 8'h09);
    push_item(OP_LOAD_B, 8'h01);
    push_item(OP_LOAD_B, 8'h02);
    push_item(OP_LOAD_B, 8'h03);
    push_item(OP_RUN, 8'h00);
    for (int k = 0; k < 6; k++) push_item(OP_LOAD_A, (k == 3) ? 8'h77 : 8'h44);
    for (int k = 0; k < 6; k++) push_item(OP_LOAD_B, 8'h44);
    push_item(OP_RUN, 8'h00);

    // Overflow: fill B past its depth, then search against a short A.
    for (int k = 0; k < BufferDepth + 2; k++) push_item(OP_LOAD_B, pick_byte(1'b1));
    for (int k = 0; k < 5; k++) push_item(OP_LOAD_A, pick_byte(1'b1));
    push_item(OP_RUN, 8'h00, 1'b1);

    items = 0;
    runs = 0;
    while (items < 550 || runs < 40) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: stray opcodes and bare loads
        push_item(opcode_t'($urandom_range(0, 3)), pick_byte(1'b0));
        items++;
        if (pending_items[$].op == OP_RUN) runs++;
        continue;
      end
      narrow = $urandom_range(0, 3) != 0;
      na = $urandom_range(0, 20);
      lead = $urandom_range(0, 5);
      seq_a.delete();
      seq_b.delete();
      for (int k = 0; k < na; k++) seq_a.push_back(pick_byte(narrow));
      for (int k = 0; k < lead; k++) seq_b.push_back(pick_byte(narrow));
      foreach (seq_a[k])
        seq_b.push_back($urandom_range(0, 5) == 0 ? pick_byte(narrow) : seq_a[k]);
      nb = seq_b.size() - $urandom_range(0, seq_b.size() < 3 ? seq_b.size() : 3);
      while (seq_b.size() > nb) void'(seq_b.pop_back());
      while (seq_a.size() != 0 || seq_b.size() != 0) begin
        if (seq_b.size() == 0 || (seq_a.size() != 0 && $urandom_range(0, 1)))
          push_item(OP_LOAD_A, seq_a.pop_front());
        else
          push_item(OP_LOAD_B, seq_b.pop_front());
        items++;
      end
      push_item(OP_RUN, pick_byte(1'b0), $urandom_range(0, 7) == 0);
      items++;
      runs++;
      if (items > 470) quiet = 1'b1;
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending_items.size() != 0 || issued != accepted || expected_matches.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Checked %0d search results over %0d input items, overflow included.",
             matches_seen, accepted);
    if (errors == 0 && expected_matches.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timed out with %0d results outstanding.", expected_matches.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
src/dlmr_pkg.sv
src/dlmr_datapath.sv
src/dlmr_ctrl.sv
src/diagonal_longest_match_realign.sv
src/dlmr_dp.sv
tb/diagonal_longest_match_realign_tb.sv
